### rtl/canq_pkg.sv
package canq_pkg;

    // Queue geometry.
    localparam int FIFO_DEPTH = 16;
    localparam int CHANNELS   = 2;
    localparam int NSLOT      = CHANNELS * FIFO_DEPTH;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int ADDR_W     = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    // Frame fields and the stored word layout: header low, data high.
    localparam int ID_W    = 29;
    localparam int LEN_W   = 4;
    localparam int DATA_W  = 64;
    localparam int HDR_W   = ID_W + 2 + LEN_W;
    localparam int FRAME_W = HDR_W + DATA_W;
    localparam int BYTES   = DATA_W / 8;

    // Operation codes of an input word.
    typedef enum logic [2:0] {
        OP_RX_PUT   = 3'd0,
        OP_RX_GET   = 3'd1,
        OP_TX_SEND  = 3'd2,
        OP_TX_DONE  = 3'd3,
        OP_RX_CLEAR = 3'd4
    } op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic pop;
        logic load;
    } canq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } canq_stat_t;

endpackage

### rtl/canq_ctrl.sv
module canq_ctrl
    import canq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  canq_stat_t stat,
    output canq_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: accept, update pointers, read the ring, hand off the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        cmd.latch = (state_reg == ST_IDLE) && in_valid;
        cmd.exec  = (state_reg == ST_EXEC);
        cmd.pop   = (state_reg == ST_POP);
        cmd.load  = (state_reg == ST_LOAD) && stat.out_free;
    end

endmodule

### rtl/canq_dp.sv
module canq_dp
    import canq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  canq_cmd_t           cmd,
    output canq_stat_t          stat,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [2:0]          opcode,
    input  logic                channel,
    input  logic                bus_full_com,
    input  logic [ID_W-1:0]     frame_id,
    input  logic                frame_ide,
    input  logic                frame_rtr,
    input  logic [LEN_W-1:0]    frame_len,
    input  logic [DATA_W-1:0]   frame_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic                transmit_valid,
    output logic [ID_W-1:0]     out_id,
    output logic                out_ide,
    output logic                out_rtr,
    output logic [LEN_W-1:0]    out_len,
    output logic [DATA_W-1:0]   out_data
);

    // Wrapping pointer increment.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    // Slot address of a pointer within a channel's region.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic ch,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(ch) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p);
    endfunction

    // Latched input word.
    logic [2:0]          op_reg;
    logic                ch_reg;
    logic                bus_reg;
    logic [HDR_W-1:0]    hdr_reg;
    logic [DATA_W-1:0]   data_reg;

    // Configuration.
    logic com_enable_reg;

    // Ring pointers and transmitter state, one set per channel.
    logic [PTR_W-1:0] rx_rd_reg  [CHANNELS];
    logic [PTR_W-1:0] rx_wr_reg  [CHANNELS];
    logic [PTR_W-1:0] tx_rd_reg  [CHANNELS];
    logic [PTR_W-1:0] tx_wr_reg  [CHANNELS];
    logic             tx_busy_reg[CHANNELS];
    logic [PTR_W-1:0] rx_rd_next  [CHANNELS];
    logic [PTR_W-1:0] rx_wr_next  [CHANNELS];
    logic [PTR_W-1:0] tx_rd_next  [CHANNELS];
    logic [PTR_W-1:0] tx_wr_next  [CHANNELS];
    logic             tx_busy_next[CHANNELS];

    // Per-item result flags.
    logic ok_reg, ok_next;
    logic hit_reg, hit_next;
    logic is_tx_reg, is_tx_next;

    // Frame stores and their registered read data.
    logic [FRAME_W-1:0] rx_mem [NSLOT];
    logic [FRAME_W-1:0] tx_mem [NSLOT];
    logic [FRAME_W-1:0] rx_rdata_reg;
    logic [FRAME_W-1:0] tx_rdata_reg;
    logic               rx_we, tx_we, rx_re, tx_re;
    logic [ADDR_W-1:0]  rx_waddr, tx_waddr, rx_raddr, tx_raddr;

    // Output register.
    logic                out_valid_reg;
    logic                ok_out_reg;
    logic                txv_out_reg;
    logic [FRAME_W-1:0]  frame_out_reg;
    logic [FRAME_W-1:0]  frame_sel;
    logic [DATA_W-1:0]   trim_data;

    logic ch_ok;
    logic send_en;

    assign ch_ok   = (32'(ch_reg) < 32'(CHANNELS));
    assign send_en = com_enable_reg && bus_reg;

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            ch_reg   <= channel;
            bus_reg  <= bus_full_com;
            hdr_reg  <= {frame_len, frame_rtr, frame_ide, frame_id};
            data_reg <= frame_data;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            com_enable_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            com_enable_reg <= cfg_wr_data;
        end
    end

    // Pointer updates: pushes and clear in the execute step, pops after.
    always_comb
    begin
        rx_rd_next   = rx_rd_reg;
        rx_wr_next   = rx_wr_reg;
        tx_rd_next   = tx_rd_reg;
        tx_wr_next   = tx_wr_reg;
        tx_busy_next = tx_busy_reg;
        ok_next      = ok_reg;
        hit_next     = hit_reg;
        is_tx_next   = is_tx_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rx_re        = 1'b0;
        tx_re        = 1'b0;
        rx_waddr     = slot_addr(ch_reg, rx_wr_reg[ch_reg]);
        tx_waddr     = slot_addr(ch_reg, tx_wr_reg[ch_reg]);
        rx_raddr     = slot_addr(ch_reg, rx_rd_reg[ch_reg]);
        tx_raddr     = slot_addr(ch_reg, tx_rd_reg[ch_reg]);

        if (cmd.exec)
        begin
            ok_next    = 1'b0;
            hit_next   = 1'b0;
            is_tx_next = 1'b0;
            if (ch_ok)
            begin
                unique case (op_t'(op_reg))
                    OP_RX_PUT:
                    begin
                        if (ptr_inc(rx_wr_reg[ch_reg]) != rx_rd_reg[ch_reg])
                        begin
                            rx_we              = 1'b1;
                            rx_wr_next[ch_reg] = ptr_inc(rx_wr_reg[ch_reg]);
                            ok_next            = 1'b1;
                        end
                    end
                    OP_TX_SEND:
                    begin
                        if (send_en &&
                            (ptr_inc(tx_wr_reg[ch_reg]) != tx_rd_reg[ch_reg]))
                        begin
                            tx_we              = 1'b1;
                            tx_wr_next[ch_reg] = ptr_inc(tx_wr_reg[ch_reg]);
                            ok_next            = 1'b1;
                        end
                    end
                    OP_RX_CLEAR:
                    begin
                        rx_wr_next[ch_reg] = rx_rd_reg[ch_reg];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (cmd.pop && ch_ok)
        begin
            unique case (op_t'(op_reg))
                OP_RX_GET:
                begin
                    if (rx_rd_reg[ch_reg] != rx_wr_reg[ch_reg])
                    begin
                        rx_re              = 1'b1;
                        rx_rd_next[ch_reg] = ptr_inc(rx_rd_reg[ch_reg]);
                        hit_next           = 1'b1;
                        ok_next            = 1'b1;
                    end
                end
                OP_TX_SEND, OP_TX_DONE:
                begin
                    // A send starts an idle transmitter; a done moves a busy one on.
                    if ((op_t'(op_reg) == OP_TX_SEND && send_en && !tx_busy_reg[ch_reg]) ||
                        (op_t'(op_reg) == OP_TX_DONE && tx_busy_reg[ch_reg]))
                    begin
                        if (tx_rd_reg[ch_reg] != tx_wr_reg[ch_reg])
                        begin
                            tx_re                = 1'b1;
                            tx_rd_next[ch_reg]   = ptr_inc(tx_rd_reg[ch_reg]);
                            tx_busy_next[ch_reg] = 1'b1;
                            hit_next             = 1'b1;
                            is_tx_next           = 1'b1;
                        end
                        else
                        begin
                            tx_busy_next[ch_reg] = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Pointer and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                rx_rd_reg[i]   <= '0;
                rx_wr_reg[i]   <= '0;
                tx_rd_reg[i]   <= '0;
                tx_wr_reg[i]   <= '0;
                tx_busy_reg[i] <= 1'b0;
            end
            ok_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            is_tx_reg <= 1'b0;
        end
        else
        begin
            rx_rd_reg   <= rx_rd_next;
            rx_wr_reg   <= rx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            tx_wr_reg   <= tx_wr_next;
            tx_busy_reg <= tx_busy_next;
            ok_reg      <= ok_next;
            hit_reg     <= hit_next;
            is_tx_reg   <= is_tx_next;
        end
    end

    // Receive frame store.
    always_ff @(posedge clk)
    begin
        if (rx_we)
        begin
            rx_mem[rx_waddr] <= {data_reg, hdr_reg};
        end
        if (rx_re)
        begin
            rx_rdata_reg <= rx_mem[rx_raddr];
        end
    end

    // Transmit frame store.
    always_ff @(posedge clk)
    begin
        if (tx_we)
        begin
            tx_mem[tx_waddr] <= {data_reg, hdr_reg};
        end
        if (tx_re)
        begin
            tx_rdata_reg <= tx_mem[tx_raddr];
        end
    end

    // Transmit data keeps only the bytes below the stored length.
    always_comb
    begin
        for (int b = 0; b < BYTES; b++)
        begin
            if (LEN_W'(b) < tx_rdata_reg[HDR_W-1 -: LEN_W])
            begin
                trim_data[8*b +: 8] = tx_rdata_reg[HDR_W + 8*b +: 8];
            end
            else
            begin
                trim_data[8*b +: 8] = 8'h00;
            end
        end
    end

    // Result frame: zero unless a frame was popped.
    always_comb
    begin
        if (!hit_reg)
        begin
            frame_sel = '0;
        end
        else if (is_tx_reg)
        begin
            frame_sel = {trim_data, tx_rdata_reg[HDR_W-1:0]};
        end
        else
        begin
            frame_sel = rx_rdata_reg;
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ok_out_reg    <= ok_reg;
            txv_out_reg   <= hit_reg && is_tx_reg;
            frame_out_reg <= frame_sel;
        end
    end

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign out_valid      = out_valid_reg;
    assign ok             = ok_out_reg;
    assign transmit_valid = txv_out_reg;
    assign out_id         = frame_out_reg[ID_W-1:0];
    assign out_ide        = frame_out_reg[ID_W];
    assign out_rtr        = frame_out_reg[ID_W+1];
    assign out_len        = frame_out_reg[HDR_W-1 -: LEN_W];
    assign out_data       = frame_out_reg[FRAME_W-1 -: DATA_W];

endmodule

### rtl/can_frame_rx_tx_queue.sv
// Per-channel CAN frame queues: a receive ring and a transmit ring per channel.
// Input channel (in_valid/in_ready) carries one command word: receive put,
// receive get, transmit send, transmit done or receive clear, with the frame.
// Output channel (out_valid/out_ready) returns exactly one result word per
// command: ok, transmit_valid and the frame read or handed to the mailbox.
// cfg_wr_en/cfg_wr_data write com_enable; write it only while the block is idle.
// Each command passes accept, pointer update, ring read and result load in turn;
// a new word is taken only once the result has been loaded, and the ring read
// step is there because the frame store read is registered.
// A finished result sits in the output register while the next word is
// accepted; if the receiver stalls, the following result waits in the load
// step and in_ready stays low until the output register frees up.
// Reset empties all rings, idles every transmitter and sets com_enable to 1.
// The frame stores are not cleared; no entry is read before it is written.
module can_frame_rx_tx_queue
    import canq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic                channel,
    input  logic                bus_full_com,
    input  logic [ID_W-1:0]     frame_id,
    input  logic                frame_ide,
    input  logic                frame_rtr,
    input  logic [LEN_W-1:0]    frame_len,
    input  logic [DATA_W-1:0]   frame_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                ok,
    output logic                transmit_valid,
    output logic [ID_W-1:0]     out_id,
    output logic                out_ide,
    output logic                out_rtr,
    output logic [LEN_W-1:0]    out_len,
    output logic [DATA_W-1:0]   out_data
);

    canq_cmd_t  cmd;
    canq_stat_t stat;

    // Sequencer.
    canq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Rings, frame stores and output register.
    canq_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .opcode         (opcode),
        .channel        (channel),
        .bus_full_com   (bus_full_com),
        .frame_id       (frame_id),
        .frame_ide      (frame_ide),
        .frame_rtr      (frame_rtr),
        .frame_len      (frame_len),
        .frame_data     (frame_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ok             (ok),
        .transmit_valid (transmit_valid),
        .out_id         (out_id),
        .out_ide        (out_ide),
        .out_rtr        (out_rtr),
        .out_len        (out_len),
        .out_data       (out_data)
    );

endmodule
